@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ hdl/mwc_pkg.sv @@
// Types and constants for the shortest covering window block.
package mwc_pkg;

  localparam int MAX_WORDS = 64;
  localparam int ID_W      = 6;
  localparam int CNT_W     = 7;
  localparam int POS_W     = 30;
  localparam int LEN_W     = 31;
  localparam int NW_W      = $clog2(MAX_WORDS + 1);
  localparam int CMP_W     = (CNT_W > NW_W) ? CNT_W : NW_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MEAS
  } state_t;

  typedef struct packed {
    logic             go;
    logic             ok;
    logic [POS_W-1:0] low_pos;
  } scan_t;

  typedef struct packed {
    logic             clr;
    logic             fresh;
    logic             least_ok;
    logic [POS_W-1:0] least_pos;
    logic [POS_W-1:0] wr_pos;
  } bcast_t;

endpackage

@@ hdl/mwc_cell.sv @@
// One table cell: latest position of one word and one stage of the least-position scan.
module mwc_cell
  import mwc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  bcast_t ctl,
  input  logic   sel,
  input  logic   wr,
  input  logic   in_use,
  output logic   hit,
  input  scan_t  scan_in,
  output scan_t  scan_out
);

  logic             seen;
  logic [POS_W-1:0] pos;
  logic             go;
  logic             ok;
  logic [POS_W-1:0] low_pos;
  logic             seen_eff;

  assign seen_eff = seen & ~ctl.fresh;
  assign hit = sel & (seen_eff ? (ctl.least_ok && (pos == ctl.least_pos)) : !ctl.least_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (wr) begin
      seen <= 1'b1;
    end else if (ctl.clr) begin
      seen <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      pos <= ctl.wr_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      go <= 1'b0;
    end else begin
      go <= scan_in.go;
    end
  end

  // fold this entry into the running minimum
  always_ff @(posedge clk) begin
    if (in_use) begin
      ok      <= scan_in.ok & seen;
      low_pos <= (pos < scan_in.low_pos) ? pos : scan_in.low_pos;
    end else begin
      ok      <= scan_in.ok;
      low_pos <= scan_in.low_pos;
    end
  end

  assign scan_out = '{go: go, ok: ok, low_pos: low_pos};

endmodule

@@ hdl/min_window_covering_all_words.sv @@
// Top level of the shortest covering window block.
//
// Each transaction is one word occurrence; it yields one result with the covered flag and the
// shortest covering window so far. An item runs accept, table update, measure when the least
// position stays put. When the word holding the least position reappears, or a new
// word arrives while some word is still unseen, a rescan wave runs through the chain of
// MAX_WORDS cells, one cell per cycle, before the measure step. The next item is accepted
// while a finished result still waits on the output register. Writing the word count
// (cfg_wr_en) clears the table, the least position and the best window, as start_req does.
module min_window_covering_all_words
  import mwc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ID_W-1:0]  word_id,
  input  logic [POS_W-1:0] position,
  input  logic             start_req,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             covered,
  output logic [LEN_W-1:0] best_length
);

  state_t             state, state_next;
  logic [CNT_W-1:0]   word_count;
  logic [ID_W-1:0]    word_id_r;
  logic [POS_W-1:0]   position_r;
  logic               start_r;
  logic               least_ok;
  logic [POS_W-1:0]   least_pos;
  logic               best_ok;
  logic [LEN_W-1:0]   best_len;
  logic               scan_go;

  logic [CMP_W-1:0]   used_n;
  logic               word_used;
  logic               need_scan;
  logic               load_out;
  logic               accept;
  logic               do_exec;
  logic               best_upd;
  logic [LEN_W-1:0]   new_len;
  logic               best_ok_next;
  logic [LEN_W-1:0]   best_len_next;
  bcast_t             ctl;
  logic [MAX_WORDS-1:0] sel;
  logic [MAX_WORDS-1:0] in_use;
  logic [MAX_WORDS-1:0] hit;
  scan_t              scan [MAX_WORDS+1];

  always_comb begin
    if (word_count == '0) begin
      used_n = CMP_W'(1);
    end else if (CMP_W'(word_count) > CMP_W'(MAX_WORDS)) begin
      used_n = CMP_W'(MAX_WORDS);
    end else begin
      used_n = CMP_W'(word_count);
    end
  end

  assign word_used = CMP_W'(word_id_r) < used_n;
  assign need_scan = word_used & (|hit);
  assign do_exec   = (state == S_EXEC);

  assign ctl = '{
    clr:       cfg_wr_en | (do_exec & start_r),
    fresh:     start_r,
    least_ok:  least_ok & ~start_r,
    least_pos: least_pos,
    wr_pos:    position_r
  };

  assign scan[0] = '{go: scan_go, ok: 1'b1, low_pos: '1};

  for (genvar i = 0; i < MAX_WORDS; i++) begin : g_cell
    assign sel[i]    = (CMP_W'(word_id_r) == CMP_W'(i));
    assign in_use[i] = (CMP_W'(i) < used_n);
    mwc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .sel      (sel[i]),
      .wr       (do_exec & sel[i] & word_used),
      .in_use   (in_use[i]),
      .hit      (hit[i]),
      .scan_in  (scan[i]),
      .scan_out (scan[i+1])
    );
  end

  // window measurement
  assign new_len  = LEN_W'({1'b0, position_r}) - LEN_W'({1'b0, least_pos}) + LEN_W'(1);
  assign best_upd = word_used & least_ok & (position_r >= least_pos) &
                    (!best_ok || (new_len < best_len));
  assign best_ok_next  = best_upd | best_ok;
  assign best_len_next = best_upd ? new_len : best_len;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = need_scan ? S_SCAN : S_MEAS;
      S_SCAN: if (scan[MAX_WORDS].go) state_next = S_MEAS;
      S_MEAS: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_MEAS: load_out = !out_valid || !out_stall;
      default: begin
        in_stall = 1'b1;
        load_out = 1'b0;
      end
    endcase
  end

  assign accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_id_r  <= word_id;
      position_r <= position;
      start_r    <= start_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= CNT_W'(1);
      least_ok   <= 1'b0;
      least_pos  <= '0;
      best_ok    <= 1'b0;
      best_len   <= '0;
      scan_go    <= 1'b0;
    end else begin
      scan_go <= do_exec & need_scan;
      if (cfg_wr_en) begin
        word_count <= cfg_wr_data;
        least_ok   <= 1'b0;
        best_ok    <= 1'b0;
        best_len   <= '0;
      end else if (do_exec && start_r) begin
        least_ok <= 1'b0;
        best_ok  <= 1'b0;
        best_len <= '0;
      end else if (state == S_SCAN && scan[MAX_WORDS].go) begin
        least_ok  <= scan[MAX_WORDS].ok;
        least_pos <= scan[MAX_WORDS].low_pos;
      end else if (load_out) begin
        best_ok  <= best_ok_next;
        best_len <= best_len_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      covered     <= best_ok_next;
      best_length <= best_ok_next ? best_len_next : '0;
    end
  end

endmodule

@@ hdl/mwc_checker.sv @@
// Port checker for the shortest covering window block, bound to the top level.
`include "assert_macros.svh"

module mwc_checker
  import mwc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic             covered,
  input logic [LEN_W-1:0] best_length
);

  `ASSERT_NEVER(a_uncovered_zero, clk, rst, out_valid && !covered && (best_length != '0))
  `ASSERT_NEVER(a_covered_nonzero, clk, rst, out_valid && covered && (best_length == '0))
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)
  `ASSERT_CLK(a_out_stable, clk, rst,
    out_valid && out_stall |=> $stable(covered) && $stable(best_length))

endmodule

bind min_window_covering_all_words mwc_checker u_mwc_checker (.*);

@@ bench/testbench.sv @@
// Self-checking testbench for the shortest covering window block, with its own predictor.
`timescale 1ns / 1ps

module testbench;
  import mwc_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int TAIL_CYCLES  = MAX_WORDS + 16;
  localparam int N_PLAN       = 25;
  localparam int N_PHASES     = 13;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CNT_W-1:0] cfg;
    logic [ID_W-1:0]  word;
    logic [POS_W-1:0] pos;
    logic             start;
    logic             typed;
    logic             cov;
    logic [LEN_W-1:0] len;
  } row_t;

  typedef struct {
    logic             cov;
    logic [LEN_W-1:0] len;
  } window_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ID_W-1:0]  word_id = '0;
  logic [POS_W-1:0] position = '0;
  logic             start_req = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             covered;
  logic [LEN_W-1:0] best_length;

  min_window_covering_all_words dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .word_id     (word_id),
    .position    (position),
    .start_req   (start_req),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .covered     (covered),
    .best_length (best_length)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [POS_W-1:0] last_pos [MAX_WORDS];
  logic             last_ok  [MAX_WORDS];
  logic [POS_W-1:0] low_pos;
  logic             low_ok;
  logic [LEN_W-1:0] short_len;
  logic             short_ok;
  logic [CNT_W-1:0] word_cfg;

  window_t pending_windows [$];

  int errors      = 0;
  int sent        = 0;
  int checked     = 0;
  int covered_cnt = 0;
  int cfg_writes  = 0;
  int cycles      = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int hold_left   = 0;

  function automatic int active_words();
    if (word_cfg == 0) return 1;
    if (word_cfg > MAX_WORDS) return MAX_WORDS;
    return int'(word_cfg);
  endfunction

  function automatic void clear_windows();
    for (int i = 0; i < MAX_WORDS; i++) begin
      last_pos[i] = '0;
      last_ok[i]  = 1'b0;
    end
    low_pos   = '0;
    low_ok    = 1'b0;
    short_len = '0;
    short_ok  = 1'b0;
  endfunction

  function automatic void find_low_pos();
    int               n;
    logic [POS_W-1:0] m;
    n = active_words();
    m = '0;
    for (int i = 0; i < n; i++) begin
      if (!last_ok[i]) begin
        low_ok  = 1'b0;
        low_pos = '0;
        return;
      end
      if (i == 0 || last_pos[i] < m) m = last_pos[i];
    end
    low_pos = m;
    low_ok  = 1'b1;
  endfunction

  function automatic window_t cover_step(logic [ID_W-1:0] w, logic [POS_W-1:0] p, logic s);
    logic             holds_low;
    logic [LEN_W-1:0] span;
    window_t          r;
    if (s) clear_windows();
    if (int'(w) < active_words()) begin
      if (!last_ok[w]) holds_low = !low_ok;
      else holds_low = low_ok && last_pos[w] == low_pos;
      last_pos[w] = p;
      last_ok[w]  = 1'b1;
      if (holds_low) find_low_pos();
      if (low_ok && p >= low_pos) begin
        span = {1'b0, p} - {1'b0, low_pos} + LEN_W'(1);
        if (!short_ok || span < short_len) begin
          short_len = span;
          short_ok  = 1'b1;
        end
      end
    end
    r.cov = short_ok;
    r.len = short_ok ? short_len : '0;
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= 30) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    if (hold_left > 0) hold_left <= hold_left - 1;

  always @(negedge clk)
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    window_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        report($sformatf("unexpected result covered=%0b len=%0d", covered, best_length));
      end else begin
        want = pending_windows.pop_front();
        checked++;
        if (covered) covered_cnt++;
        if (covered !== want.cov)
          report($sformatf("result %0d covered=%0b want %0b", checked, covered, want.cov));
        if (best_length !== want.len)
          report($sformatf("result %0d best_length=%0d want %0d", checked, best_length,
                           want.len));
      end
    end
  end

  // Offer one transaction, hold until accepted, then record its expected window.
  task automatic offer(logic [ID_W-1:0] w, logic [POS_W-1:0] p, logic s,
                       logic typed = 1'b0, logic tcov = 1'b0, logic [LEN_W-1:0] tlen = '0);
    window_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    word_id   <= w;
    position  <= p;
    start_req <= s;
    do @(posedge clk); while (in_stall);
    r = cover_step(w, p, s);
    if (typed) begin
      r.cov = tcov;
      r.len = tlen;
    end
    pending_windows.push_back(r);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_word_count(logic [CNT_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    word_cfg = v;
    clear_windows();
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(logic [CNT_W-1:0] cfg, int mode, int count, bit press);
    logic [POS_W-1:0] cur;
    logic [POS_W-1:0] p;
    logic [ID_W-1:0]  w;
    logic             s;
    int               n;
    int               rr;
    int               r;
    load_word_count(cfg);
    gap_pct   = (mode == 1) ? 64 : (mode == 3) ? 8 : 0;
    stall_pct = (mode == 2) ? 64 : (mode == 3) ? 8 : 0;
    if (press) hold_left = 500;
    n  = active_words();
    rr = 0;
    cur = POS_W'($urandom());
    if ($urandom_range(0, 3) == 0) cur = '1 - POS_W'($urandom_range(0, 200));
    for (int k = 0; k < count; k++) begin
      s = ($urandom_range(0, 40 * n) == 0);
      if (s) begin
        cur = POS_W'($urandom());
        rr  = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        w  = ID_W'(rr);
        rr = (rr + 1 + ($urandom_range(0, 7) == 0)) % n;
      end else if (r < 90) begin
        w = ID_W'($urandom_range(0, n - 1));
      end else begin
        w = ID_W'($urandom_range(0, 63));
      end
      cur = cur + POS_W'($urandom_range(0, 3));
      p = cur;
      if ($urandom_range(0, 99) < 4) p = cur - POS_W'($urandom_range(1, 40));
      offer(w, p, s);
    end
  endtask

  row_t plan [0:N_PLAN-1] = '{
    '{ROW_ITEM, 7'd0,   6'd0,  30'd5,          1'b0, 1'b1, 1'b1, 31'd1},
    '{ROW_ITEM, 7'd0,   6'd63, 30'd6,          1'b0, 1'b1, 1'b1, 31'd1},
    '{ROW_ITEM, 7'd0,   6'd0,  30'd9,          1'b0, 1'b1, 1'b1, 31'd1},
    '{ROW_CFG,  7'd2,   6'd0,  30'd0,          1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd0,  30'd0,          1'b0, 1'b1, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd1,  30'h3FFF_FFFF,  1'b0, 1'b1, 1'b1, 31'h4000_0000},
    '{ROW_ITEM, 7'd0,   6'd1,  30'h3FFF_FFFF,  1'b1, 1'b1, 1'b0, 31'd0},
    '{ROW_CFG,  7'd0,   6'd0,  30'd0,          1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd0,  30'd0,          1'b0, 1'b1, 1'b1, 31'd1},
    '{ROW_CFG,  7'd127, 6'd0,  30'd0,          1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd63, 30'd100,        1'b0, 1'b1, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd5,  30'd101,        1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_CFG,  7'd64,  6'd0,  30'd0,          1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd63, 30'h3FFF_FFFF,  1'b0, 1'b1, 1'b0, 31'd0},
    '{ROW_CFG,  7'd3,   6'd0,  30'd0,          1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd0,  30'd10,         1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd1,  30'd12,         1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd2,  30'd15,         1'b0, 1'b1, 1'b1, 31'd6},
    '{ROW_ITEM, 7'd0,   6'd0,  30'd20,         1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd1,  30'd21,         1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd2,  30'd22,         1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd1,  30'd3,          1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd0,  30'd22,         1'b1, 1'b1, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd1,  30'd22,         1'b0, 1'b0, 1'b0, 31'd0},
    '{ROW_ITEM, 7'd0,   6'd2,  30'd22,         1'b0, 1'b0, 1'b0, 31'd0}
  };

  logic [CNT_W-1:0] phase_cfg [0:N_PHASES-1] =
    '{7'd1, 7'd2, 7'd3, 7'd64, 7'd5, 7'd0, 7'd127, 7'd8, 7'd4, 7'd65, 7'd6, 7'd2, 7'd3};
  int phase_len [0:N_PHASES-1] = '{60, 70, 70, 160, 70, 40, 140, 70, 70, 40, 70, 60, 60};

  initial begin
    word_cfg = CNT_W'(1);
    clear_windows();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_PLAN; i++) begin
      if (plan[i].kind == ROW_CFG) load_word_count(plan[i].cfg);
      else offer(plan[i].word, plan[i].pos, plan[i].start,
                 plan[i].typed, plan[i].cov, plan[i].len);
    end

    // Last phase holds the receiver off while the sender keeps offering.
    for (int ph = 0; ph < N_PHASES; ph++)
      run_phase(phase_cfg[ph], (ph == N_PHASES - 1) ? 0 : ph % 4, phase_len[ph],
                ph == N_PHASES - 1);

    settle();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_windows.size() != 0)
      report($sformatf("%0d expected results never arrived", pending_windows.size()));

    $display("ran %0d transactions over %0d word-count settings, %0d cycles",
             sent, cfg_writes, cycles);
    $display("checked %0d results, %0d of them covered, %0d mismatches",
             checked, covered_cnt, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
